FILE: design/psvm_pkg.sv
// ----------------------------------------------------------------------------
// psvm_pkg: shared types and constants of the periodic sphere voxel marker
// Field widths, fixed-point formats, operation codes and register indexes.
// ----------------------------------------------------------------------------
package psvm_pkg;

	// Input word fields.
	localparam int OP_W    = 2;
	localparam int CIN_W   = 6;
	localparam int RAD_W   = 16;
	localparam int SCALE_W = 10;

	// Shared multiplier operand and product widths (radius in Q10.16, square in Q20.32).
	localparam int MUL_W  = 26;
	localparam int PROD_W = 2 * MUL_W;
	localparam int FRAC_W = 32;
	localparam int THR_W  = PROD_W - FRAC_W + 1;

	// Width of ceil(radius) before clamping.
	localparam int HC_W = MUL_W - 16 + 1;

	// Paint uses a fixed factor of 1.0 in Q2.8.
	localparam logic [SCALE_W-1:0] PAINT_SCALE = 10'd256;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 10'd256;

	// Configuration port.
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic REG_OVERLAP_SCALE = 1'b0;

	typedef enum logic [OP_W-1:0] {
		OP_CHECK = 2'd0,
		OP_PAINT = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

endpackage

FILE: design/psvm_mul_unit.sv
// ----------------------------------------------------------------------------
// psvm_mul_unit: shared registered multiplier
// Forms the widened radius, its square and every per-voxel offset square.
// ----------------------------------------------------------------------------
module psvm_mul_unit
	import psvm_pkg::*;
(
	input  logic              clk,
	input  logic [MUL_W-1:0]  a,
	input  logic [MUL_W-1:0]  b,
	output logic [PROD_W-1:0] prod
);

	always_ff @(posedge clk) begin
		prod <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

FILE: design/psvm_occ_mem.sv
// ----------------------------------------------------------------------------
// psvm_occ_mem: occupancy bit memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module psvm_occ_mem #(
	parameter int DEPTH = 262144,
	parameter int AW    = 18
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);

	logic mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: design/periodic_sphere_voxel_marker.sv
// ----------------------------------------------------------------------------
// periodic_sphere_voxel_marker: occupancy map of a periodic voxel grid
// Paints spheres into a one-bit map and checks new spheres for overlap.
// ----------------------------------------------------------------------------
// The block holds a GRID_DIM^3 one-bit occupancy map of a grid that wraps at
// every face, and takes one request word at a time. Op 0 widens the Q8.8
// radius by overlap_scale and answers whether any marked voxel lies strictly
// inside under minimum-image distance; op 1 marks every voxel strictly
// inside the unwidened radius; op 2 clears the map; op 3 does nothing. Every
// request returns exactly one word with done_res set. A sphere request walks
// a box of cnt^3 voxels, cnt = min(2*h+1, GRID_DIM) where h is ceil(radius)
// clamped to GRID_DIM-1, one voxel per cycle through a single shared
// multiplier, with a plane state before each box plane and a row state before
// each box row for the plane and row offset squares; an overlap check leaves
// its walk in the cycle after the first marked voxel inside is compared.
// Clearing writes one voxel a cycle through the memory's write port over all
// GRID_DIM^3 voxels; the same clearing pass runs after reset, and the input
// side stays not ready until it ends, while configuration writes are taken
// as ever.
// A finished result waits in an output register, so the next request word
// is taken while the previous result is still unclaimed.
// ----------------------------------------------------------------------------
module periodic_sphere_voxel_marker
	import psvm_pkg::*;
#(
	parameter int GRID_DIM = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,

	// Request words.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// s_tdata fields from bit 0 up: center_x[5:0], center_y[11:6],
	// center_z[17:12], radius[33:18], zero fill [39:34].
	input  logic [39:0]           s_tdata,
	// s_tuser fields from bit 0 up: op[1:0].
	input  logic [OP_W-1:0]       s_tuser,

	// Result words.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// m_tdata fields from bit 0 up: overlap_found[0], done_res[1], zero fill [7:2].
	output logic [7:0]            m_tdata,

	// Configuration port.
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	// Grid geometry derived from the grid size.
	localparam int CW     = $clog2(GRID_DIM);
	localparam int RW     = (CW + 1 > CIN_W) ? CW + 1 : CIN_W;
	localparam int VOXELS = GRID_DIM * GRID_DIM * GRID_DIM;
	localparam int AW     = $clog2(VOXELS);
	localparam int G2     = GRID_DIM * GRID_DIM;
	localparam int SQ_W   = 2 * CW;
	localparam int D2_W   = 2 * CW + 2;
	localparam int CMP_W  = (THR_W > D2_W) ? THR_W : D2_W;

	typedef enum logic [12:0] {
		ST_IDLE  = 13'b0000000000001,
		ST_MOD   = 13'b0000000000010,
		ST_MUL1  = 13'b0000000000100,
		ST_MUL2  = 13'b0000000001000,
		ST_SETUP = 13'b0000000010000,
		ST_START = 13'b0000000100000,
		ST_BASE  = 13'b0000001000000,
		ST_XS    = 13'b0000010000000,
		ST_YS    = 13'b0000100000000,
		ST_ZS    = 13'b0001000000000,
		ST_DRAIN = 13'b0010000000000,
		ST_CLR   = 13'b0100000000000,
		ST_DONE  = 13'b1000000000000
	} state_t;

	// Minimum-image offset between two coordinates inside the grid.
	function automatic logic [CW-1:0] wrap_off(input logic [CW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] d;
		logic [CW:0] e;
		d = (a >= b) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, b} - {1'b0, a});
		e = (CW + 1)'(GRID_DIM) - d;
		return (d < e) ? d[CW-1:0] : e[CW-1:0];
	endfunction

	// Next coordinate along one axis, wrapping at the grid face.
	function automatic logic [CW-1:0] next_coord(input logic [CW-1:0] c);
		return (c == CW'(GRID_DIM - 1)) ? '0 : c + 1'b1;
	endfunction

	state_t              state_q;
	logic                boot_q;
	logic [SCALE_W-1:0]  scale_q;

	// Request registers.
	op_t                 op_q;
	logic [RW-1:0]       cx_q, cy_q, cz_q;
	logic [RAD_W-1:0]    radius_q;

	// Sphere setup.
	logic [MUL_W-1:0]    rq_q;
	logic [THR_W-1:0]    thr_q;
	logic [CW-1:0]       h_q;
	logic [CW-1:0]       last_q;
	logic [CW-1:0]       sx_q, sy_q, sz_q;

	// Box walk.
	logic [CW-1:0]       i_q, j_q, k_q;
	logic [CW-1:0]       xi_q, yi_q, zi_q;
	logic [AW-1:0]       xbase_q, ybase_q, sybase_q, xybase_q;
	logic                xnew_q;
	logic [SQ_W-1:0]     sqx_q;
	logic [SQ_W:0]       dxy_q;
	logic                found_q;
	logic [AW-1:0]       clr_q;

	// Compare stage, aligned with the multiplier product and the read data.
	logic                valid_s1;
	logic [AW-1:0]       addr_s1;

	// Output register.
	logic                out_valid_q;
	logic                out_found_q;

	logic [MUL_W-1:0]    mul_a, mul_b;
	logic [PROD_W-1:0]   prod;
	logic [CW-1:0]       cxg, cyg, czg;
	logic [CW-1:0]       dx, dy, dz;
	logic [AW-1:0]       walk_addr;
	logic                rdata;
	logic [D2_W-1:0]     d2;
	logic                in_ball;
	logic                hit;
	logic                paint_we;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic                mem_wdata;
	logic                mod_done;
	logic [HC_W:0]       hc_sum;
	logic [HC_W-1:0]     hc;
	logic [CW-1:0]       h_c;
	logic [CW:0]         h2_c;
	logic [CW:0]         sxs, sys, szs;
	logic                cfg_we;
	logic                in_acc;
	logic                out_load;

	assign in_acc   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign pready   = 1'b1;
	assign cfg_we   = psel && penable && pwrite && pready && (paddr[2] == REG_OVERLAP_SCALE);
	assign prdata   = (paddr[2] == REG_OVERLAP_SCALE) ? CFG_DATA_W'(scale_q) : '0;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, 1'b1, out_found_q};

	assign cxg = cx_q[CW-1:0];
	assign cyg = cy_q[CW-1:0];
	assign czg = cz_q[CW-1:0];
	assign dx  = wrap_off(cxg, xi_q);
	assign dy  = wrap_off(cyg, yi_q);
	assign dz  = wrap_off(czg, zi_q);

	assign walk_addr = xybase_q + AW'(zi_q);

	// The center must be reduced into the grid before the walk starts.
	assign mod_done = (cx_q < RW'(GRID_DIM)) && (cy_q < RW'(GRID_DIM)) &&
		(cz_q < RW'(GRID_DIM));

	// Half-width of the box: ceil of the Q10.16 radius, clamped so the walk
	// wraps at most once. The box side is 2h+1 unless that exceeds the grid.
	assign hc_sum = (HC_W + 1)'(({1'b0, rq_q} + (MUL_W + 1)'(16'hFFFF)) >> 16);
	assign hc     = hc_sum[HC_W-1:0];
	assign h_c    = (hc > HC_W'(GRID_DIM - 1)) ? CW'(GRID_DIM - 1) : hc[CW-1:0];
	assign h2_c   = {h_c, 1'b0};

	// First box coordinate on each axis: center minus h, wrapped once.
	assign sxs = (CW + 1)'(cxg) + (CW + 1)'(GRID_DIM) - (CW + 1)'(h_q);
	assign sys = (CW + 1)'(cyg) + (CW + 1)'(GRID_DIM) - (CW + 1)'(h_q);
	assign szs = (CW + 1)'(czg) + (CW + 1)'(GRID_DIM) - (CW + 1)'(h_q);

	// Compare stage: squared distance of the voxel issued in the previous
	// cycle against the rounded-up integer part of the squared radius.
	assign d2       = D2_W'(dxy_q) + D2_W'(prod[SQ_W-1:0]);
	assign in_ball  = CMP_W'(d2) < CMP_W'(thr_q);
	assign hit      = valid_s1 && (op_q == OP_CHECK) && in_ball && rdata;
	assign paint_we = valid_s1 && (op_q == OP_PAINT) && in_ball;

	assign mem_we    = (state_q == ST_CLR) || paint_we;
	assign mem_waddr = (state_q == ST_CLR) ? clr_q : addr_s1;
	assign mem_wdata = (state_q != ST_CLR);

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MUL1: begin
				mul_a = MUL_W'(radius_q);
				mul_b = (op_q == OP_CHECK) ? MUL_W'(scale_q) : MUL_W'(PAINT_SCALE);
			end
			ST_MUL2: begin
				mul_a = prod[MUL_W-1:0];
				mul_b = prod[MUL_W-1:0];
			end
			ST_XS: begin
				mul_a = MUL_W'(dx);
				mul_b = MUL_W'(dx);
			end
			ST_YS: begin
				mul_a = MUL_W'(dy);
				mul_b = MUL_W'(dy);
			end
			ST_ZS: begin
				mul_a = MUL_W'(dz);
				mul_b = MUL_W'(dz);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	psvm_mul_unit u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	psvm_occ_mem #(
		.DEPTH (VOXELS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (walk_addr),
		.rdata (rdata)
	);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (cfg_we) begin
			scale_q <= pwdata[SCALE_W-1:0];
		end
	end

	// Output register: a finished result waits here while the next word is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_found_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			out_found_q <= found_q && (op_q == OP_CHECK);
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Compare-stage registers, loaded behind every voxel the walk issues.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_ZS);
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= walk_addr;
	end

	// Sequencer. After reset it first sweeps the map clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLR;
			boot_q   <= 1'b1;
			clr_q    <= '0;
			op_q     <= OP_NONE;
			cx_q     <= '0;
			cy_q     <= '0;
			cz_q     <= '0;
			radius_q <= '0;
			rq_q     <= '0;
			thr_q    <= '0;
			h_q      <= '0;
			last_q   <= '0;
			sx_q     <= '0;
			sy_q     <= '0;
			sz_q     <= '0;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			xi_q     <= '0;
			yi_q     <= '0;
			zi_q     <= '0;
			xbase_q  <= '0;
			ybase_q  <= '0;
			sybase_q <= '0;
			xybase_q <= '0;
			xnew_q   <= 1'b0;
			sqx_q    <= '0;
			dxy_q    <= '0;
			found_q  <= 1'b0;
		end else begin
			// A marked voxel inside the widened sphere is sticky until the next word.
			if (hit) begin
				found_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						op_q     <= op_t'(s_tuser);
						cx_q     <= RW'(s_tdata[5:0]);
						cy_q     <= RW'(s_tdata[11:6]);
						cz_q     <= RW'(s_tdata[17:12]);
						radius_q <= s_tdata[33:18];
						found_q  <= 1'b0;
						state_q  <= ST_MOD;
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						unique case (op_q)
							OP_CHECK, OP_PAINT: state_q <= ST_MUL1;
							OP_CLEAR:           state_q <= ST_CLR;
							OP_NONE:            state_q <= ST_DONE;
							default:            state_q <= ST_DONE;
						endcase
					end else begin
						if (cx_q >= RW'(GRID_DIM)) cx_q <= cx_q - RW'(GRID_DIM);
						if (cy_q >= RW'(GRID_DIM)) cy_q <= cy_q - RW'(GRID_DIM);
						if (cz_q >= RW'(GRID_DIM)) cz_q <= cz_q - RW'(GRID_DIM);
					end
				end
				ST_MUL1: begin
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					// The product now holds the Q10.16 radius; its square follows.
					rq_q    <= prod[MUL_W-1:0];
					state_q <= ST_SETUP;
				end
				ST_SETUP: begin
					// Inside means d2 * 2^32 < rsq, i.e. d2 below the rounded-up high part.
					thr_q  <= THR_W'(prod[PROD_W-1:FRAC_W]) + THR_W'(|prod[FRAC_W-1:0]);
					h_q    <= h_c;
					last_q <= (h2_c >= (CW + 1)'(GRID_DIM)) ? CW'(GRID_DIM - 1) : h2_c[CW-1:0];
					if (rq_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					sx_q <= (sxs >= (CW + 1)'(GRID_DIM)) ?
						CW'(sxs - (CW + 1)'(GRID_DIM)) : sxs[CW-1:0];
					sy_q <= (sys >= (CW + 1)'(GRID_DIM)) ?
						CW'(sys - (CW + 1)'(GRID_DIM)) : sys[CW-1:0];
					sz_q <= (szs >= (CW + 1)'(GRID_DIM)) ?
						CW'(szs - (CW + 1)'(GRID_DIM)) : szs[CW-1:0];
					state_q <= ST_BASE;
				end
				ST_BASE: begin
					i_q      <= '0;
					j_q      <= '0;
					k_q      <= '0;
					xi_q     <= sx_q;
					yi_q     <= sy_q;
					zi_q     <= sz_q;
					xbase_q  <= AW'(sx_q) * AW'(G2);
					ybase_q  <= AW'(sy_q) * AW'(GRID_DIM);
					sybase_q <= AW'(sy_q) * AW'(GRID_DIM);
					state_q  <= ST_XS;
				end
				ST_XS: begin
					// The plane offset square is fed here and taken up in the row state.
					xnew_q <= 1'b1;
					if (hit) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_YS;
					end
				end
				ST_YS: begin
					if (xnew_q) begin
						sqx_q <= prod[SQ_W-1:0];
					end
					xnew_q   <= 1'b0;
					xybase_q <= xbase_q + ybase_q;
					if (hit) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_ZS;
					end
				end
				ST_ZS: begin
					// The row offset square sits in the product during the first voxel.
					if (k_q == '0) begin
						dxy_q <= (SQ_W + 1)'(sqx_q) + (SQ_W + 1)'(prod[SQ_W-1:0]);
					end
					if (hit) begin
						state_q <= ST_DONE;
					end else if (k_q == last_q) begin
						k_q  <= '0;
						zi_q <= sz_q;
						if (j_q == last_q) begin
							j_q     <= '0;
							yi_q    <= sy_q;
							ybase_q <= sybase_q;
							if (i_q == last_q) begin
								state_q <= ST_DRAIN;
							end else begin
								i_q     <= i_q + 1'b1;
								xi_q    <= next_coord(xi_q);
								xbase_q <= (xi_q == CW'(GRID_DIM - 1)) ? '0 : xbase_q + AW'(G2);
								state_q <= ST_XS;
							end
						end else begin
							j_q     <= j_q + 1'b1;
							yi_q    <= next_coord(yi_q);
							ybase_q <= (yi_q == CW'(GRID_DIM - 1)) ? '0 :
								ybase_q + AW'(GRID_DIM);
							state_q <= ST_YS;
						end
					end else begin
						k_q  <= k_q + 1'b1;
						zi_q <= next_coord(zi_q);
					end
				end
				ST_DRAIN: begin
					// The last voxel of the box is compared in this cycle.
					state_q <= ST_DONE;
				end
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(VOXELS - 1)) begin
						clr_q  <= '0;
						boot_q <= 1'b0;
						if (boot_q) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: dv/periodic_sphere_voxel_marker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_sphere_voxel_marker_tb: self-checking bench of the voxel marker
// Drives request words in random bursts and predicts each result word from a
// private copy of the occupancy map. Result words are compared field by field
// while the receiver stalls on a pattern of its own. The overlap scale
// register is set between phases, and its extremes are among the settings.
// ----------------------------------------------------------------------------
module periodic_sphere_voxel_marker_tb;
	import psvm_pkg::*;

	localparam int unsigned GRID        = 64;
	localparam int unsigned VOXELS      = GRID * GRID * GRID;
	localparam int unsigned CYCLE_LIMIT = 4000000;
	localparam int unsigned DRAIN_WAIT  = 64;
	localparam int unsigned REPORT_MAX  = 10;

	// Receiver stall patterns.
	localparam int unsigned RX_ALWAYS   = 0;
	localparam int unsigned RX_RANDOM   = 1;
	localparam int unsigned RX_PERIODIC = 2;

	localparam logic [CFG_ADDR_W-1:0] SCALE_ADDR = CFG_ADDR_W'(4 * int'(REG_OVERLAP_SCALE));
	localparam logic [SCALE_W-1:0]    SCALE_MAX  = '1;

	typedef struct packed {
		logic overlap_found;
		logic done_res;
	} result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	// s_tdata fields from bit 0 up: center_x, center_y, center_z, radius, zero fill.
	logic [39:0]           s_tdata;
	// s_tuser fields from bit 0 up: op.
	logic [OP_W-1:0]       s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	// m_tdata fields from bit 0 up: overlap_found, done_res, zero fill.
	logic [7:0]            m_tdata;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	// Private copy of the block's state and its one register.
	bit                    occ_map [VOXELS];
	int unsigned           scale_q28;

	// Result words predicted for accepted requests, oldest first.
	result_t               pending_results [$];
	int unsigned           mismatches;
	int unsigned           cycle_count;
	int unsigned           burst_left;
	int unsigned           rx_mode;
	int unsigned           rx_left;
	int unsigned           rx_phase;

	// Center of the most recent paint, so that checks can aim near it.
	logic [CIN_W-1:0]      last_x;
	logic [CIN_W-1:0]      last_y;
	logic [CIN_W-1:0]      last_z;

	periodic_sphere_voxel_marker #(
		.GRID_DIM(GRID)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// The watchdog ends the run if the block stops making progress. It is
	// sized from the slowest correct run: the clearing pass after reset, one
	// paint and one clear that each cover the whole grid, and the random
	// traffic of small spheres, stalls and sender gaps, taken about four
	// times over.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	// Counts a mismatch and reports only the first few of them.
	task automatic note_mismatch(input string what, input longint unsigned expected,
			input longint unsigned actual);
		mismatches++;
		if (mismatches <= REPORT_MAX) begin
			$display("mismatch in %s: expected %0h, actual %0h", what, expected, actual);
		end
	endtask

	// Minimum-image distance along one axis of the periodic grid.
	function automatic longint unsigned axis_offset(input int unsigned a, input int unsigned b);
		int unsigned d;
		int unsigned e;
		d = (a >= b) ? a - b : b - a;
		e = GRID - d;
		return (d < e) ? d : e;
	endfunction

	// Walks the box around the center for a Q10.16 radius. A check returns 1
	// at the first marked voxel strictly inside; a paint marks every voxel
	// strictly inside and returns 0. The half-width is clamped so that each
	// axis wraps at most once.
	function automatic bit sphere_walk(input int unsigned cx, input int unsigned cy,
			input int unsigned cz, input longint unsigned rq, input bit paint);
		longint unsigned rsq;
		longint unsigned half_q;
		longint unsigned d2;
		longint unsigned dx;
		longint unsigned dy;
		longint unsigned dz;
		int unsigned     half;
		int unsigned     cnt;
		int unsigned     sx;
		int unsigned     sy;
		int unsigned     sz;
		int unsigned     xi;
		int unsigned     yi;
		int unsigned     zi;
		int unsigned     i;
		int unsigned     j;
		int unsigned     k;
		if (rq == 0) begin
			return 1'b0;
		end
		rsq    = rq * rq;
		half_q = (rq + 64'hFFFF) >> 16;
		half   = (half_q > GRID - 1) ? GRID - 1 : int'(half_q);
		cnt    = 2 * half + 1;
		if (cnt > GRID) begin
			cnt = GRID;
		end
		sx = (cx + GRID - half) % GRID;
		sy = (cy + GRID - half) % GRID;
		sz = (cz + GRID - half) % GRID;
		for (i = 0; i < cnt; i++) begin
			xi = (sx + i) % GRID;
			dx = axis_offset(cx, xi);
			for (j = 0; j < cnt; j++) begin
				yi = (sy + j) % GRID;
				dy = axis_offset(cy, yi);
				for (k = 0; k < cnt; k++) begin
					zi = (sz + k) % GRID;
					dz = axis_offset(cz, zi);
					d2 = dx * dx + dy * dy + dz * dz;
					if (rsq > (d2 << 32)) begin
						if (paint) begin
							occ_map[(xi * GRID + yi) * GRID + zi] = 1'b1;
						end else if (occ_map[(xi * GRID + yi) * GRID + zi]) begin
							return 1'b1;
						end
					end
				end
			end
		end
		return 1'b0;
	endfunction

	// Works out the result word of one accepted request and updates the
	// private map the way the block updates its own.
	function automatic result_t predict_request(input op_t op, input logic [CIN_W-1:0] cx,
			input logic [CIN_W-1:0] cy, input logic [CIN_W-1:0] cz,
			input logic [RAD_W-1:0] radius);
		result_t res;
		res.overlap_found = 1'b0;
		res.done_res      = 1'b1;
		case (op)
			OP_CHECK: begin
				res.overlap_found = sphere_walk(cx % GRID, cy % GRID, cz % GRID,
					longint'(radius) * scale_q28, 1'b0);
			end
			OP_PAINT: begin
				void'(sphere_walk(cx % GRID, cy % GRID, cz % GRID,
					longint'(radius) << 8, 1'b1));
			end
			OP_CLEAR: begin
				foreach (occ_map[v]) begin
					occ_map[v] = 1'b0;
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	// Sends one request word. Between bursts the valid line drops for a
	// random gap; now and then the gap is long enough to land in the middle
	// of a sphere walk instead of right after the handshake.
	task automatic send_request(input op_t op, input logic [CIN_W-1:0] cx,
			input logic [CIN_W-1:0] cy, input logic [CIN_W-1:0] cz,
			input logic [RAD_W-1:0] radius);
		int unsigned gap;
		if (burst_left == 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 1500) : $urandom_range(1, 12);
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 8);
		end else begin
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, radius, cz, cy, cx};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(predict_request(op, cx, cy, cz, radius));
		burst_left--;
	endtask

	// Drops the valid line and waits until every predicted word has come.
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apb_read(input logic [CFG_ADDR_W-1:0] addr, output logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Reads the overlap scale back and compares it with the private copy.
	task automatic check_overlap_scale();
		logic [CFG_DATA_W-1:0] value;
		apb_read(SCALE_ADDR, value);
		if (value !== CFG_DATA_W'(scale_q28)) begin
			note_mismatch("overlap_scale readback", scale_q28, value);
		end
	endtask

	// The register is only written once the block has answered everything.
	task automatic write_overlap_scale(input logic [SCALE_W-1:0] value);
		wait_idle();
		apb_write(SCALE_ADDR, CFG_DATA_W'(value));
		scale_q28 = value;
		check_overlap_scale();
	endtask

	// A zero radius holds no voxel, neither for a check nor for a paint.
	task automatic test_zero_radius();
		send_request(OP_CHECK, 6'd0, 6'd0, 6'd0, 16'h0000);
		send_request(OP_PAINT, 6'd63, 6'd63, 6'd63, 16'h0000);
		send_request(OP_CHECK, 6'd63, 6'd63, 6'd63, 16'h0100);
	endtask

	// Spheres at the grid corner reach across the faces, and repainting a
	// marked voxel leaves it marked.
	task automatic test_periodic_wrap();
		send_request(OP_PAINT, 6'd0, 6'd0, 6'd0, 16'h0180);
		send_request(OP_CHECK, 6'd63, 6'd0, 6'd0, 16'h0100);
		send_request(OP_CHECK, 6'd62, 6'd62, 6'd62, 16'h0100);
		send_request(OP_CHECK, 6'd62, 6'd62, 6'd62, 16'h0200);
		send_request(OP_PAINT, 6'd63, 6'd0, 6'd0, 16'h0100);
		send_request(OP_CHECK, 6'd1, 6'd63, 6'd0, 16'h0101);
	endtask

	// The undefined op must leave the map alone and still answer.
	task automatic test_undefined_op();
		send_request(OP_NONE, 6'd63, 6'd63, 6'd63, 16'hFFFF);
		send_request(OP_NONE, 6'd0, 6'd0, 6'd0, 16'h0000);
		send_request(OP_CHECK, 6'd0, 6'd0, 6'd0, 16'h0100);
	endtask

	// The largest radius clamps the box to the whole grid. The check is
	// aimed so that its walk starts on a marked voxel and stops at once; the
	// paint then fills every voxel, and the clear empties the map again.
	task automatic test_full_grid();
		send_request(OP_PAINT, 6'd6, 6'd6, 6'd6, 16'h0100);
		send_request(OP_CHECK, 6'd5, 6'd5, 6'd5, 16'hFFFF);
		send_request(OP_PAINT, 6'd63, 6'd63, 6'd63, 16'hFFFF);
		send_request(OP_CHECK, 6'd31, 6'd17, 6'd44, 16'h0001);
		send_request(OP_CLEAR, 6'd42, 6'd21, 6'd7, 16'h1234);
		send_request(OP_CHECK, 6'd5, 6'd5, 6'd5, 16'h0800);
		send_request(OP_CHECK, 6'd0, 6'd0, 6'd0, 16'h0100);
	endtask

	// A check finds the painted voxel under the widest overlap scale and
	// misses it under the zero and the unit overlap scale.
	task automatic test_overlap_scale();
		write_overlap_scale(SCALE_MAX);
		send_request(OP_PAINT, 6'd10, 6'd10, 6'd10, 16'h0100);
		send_request(OP_CHECK, 6'd13, 6'd10, 6'd10, 16'h0100);
		write_overlap_scale('0);
		send_request(OP_CHECK, 6'd10, 6'd10, 6'd10, 16'hFFFF);
		write_overlap_scale(SCALE_RESET);
		send_request(OP_CHECK, 6'd13, 6'd10, 6'd10, 16'h0100);
	endtask

	// One phase of random traffic under a fixed scale. Checks are often aimed
	// near the last paint so that both answers come up. Paint radii stay at
	// most 4, now and then 8, and a check's widened radius at most 4, except
	// under a zero scale, where a check never walks and so takes any radius.
	task automatic run_random_phase(input logic [SCALE_W-1:0] scale, input int unsigned count);
		logic [CIN_W-1:0] cx;
		logic [CIN_W-1:0] cy;
		logic [CIN_W-1:0] cz;
		logic [RAD_W-1:0] radius;
		int unsigned      roll;
		int unsigned      cap;
		int unsigned      n;
		write_overlap_scale(scale);
		for (n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if ($urandom_range(0, 1) == 1) begin
				cx = last_x + CIN_W'($urandom_range(0, 6)) - CIN_W'(3);
				cy = last_y + CIN_W'($urandom_range(0, 6)) - CIN_W'(3);
				cz = last_z + CIN_W'($urandom_range(0, 6)) - CIN_W'(3);
			end else begin
				cx = CIN_W'($urandom);
				cy = CIN_W'($urandom);
				cz = CIN_W'($urandom);
			end
			if (roll < 8) begin
				send_request(OP_NONE, cx, cy, cz, RAD_W'($urandom));
			end else if (roll < 45) begin
				radius = ($urandom_range(0, 39) == 0) ? 16'h0800 : RAD_W'($urandom_range(0, 16'h0400));
				last_x = cx;
				last_y = cy;
				last_z = cz;
				send_request(OP_PAINT, cx, cy, cz, radius);
			end else begin
				if (scale == 0) begin
					radius = RAD_W'($urandom);
				end else begin
					cap = (4 << 16) / scale;
					if (cap > 16'hFFFF) begin
						cap = 16'hFFFF;
					end
					radius = RAD_W'($urandom_range(0, cap));
				end
				send_request(OP_CHECK, cx, cy, cz, radius);
			end
		end
	endtask

	task automatic test_random_traffic();
		run_random_phase('0, 25);
		run_random_phase(SCALE_MAX, 25);
		run_random_phase(SCALE_W'($urandom_range(1, 1022)), 25);
		run_random_phase(SCALE_W'($urandom_range(1, 1022)), 25);
	endtask

	// Receiver side: the ready line follows one of three patterns, and the
	// pattern is drawn anew whenever its random stretch runs out, so that
	// stretches with no stall alternate with random and periodic back-pressure.
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(RX_ALWAYS, RX_PERIODIC);
			rx_left = $urandom_range(50, 600);
		end
		rx_left--;
		rx_phase++;
		case (rx_mode)
			RX_ALWAYS: m_tready <= 1'b1;
			RX_RANDOM: m_tready <= ($urandom_range(0, 1) == 1);
			default:   m_tready <= ((rx_phase % 7) >= 3);
		endcase
	end

	// Every accepted result word is checked against the oldest prediction.
	always @(posedge clk) begin
		result_t exp;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				note_mismatch("unexpected result word", 0, m_tdata);
			end else begin
				exp = pending_results.pop_front();
				if (m_tdata[0] !== exp.overlap_found) begin
					note_mismatch("overlap_found", exp.overlap_found, m_tdata[0]);
				end
				if (m_tdata[1] !== exp.done_res) begin
					note_mismatch("done_res", exp.done_res, m_tdata[1]);
				end
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = OP_CHECK;
		m_tready   = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		scale_q28  = SCALE_RESET;
		mismatches = 0;
		burst_left = 0;
		rx_mode    = RX_ALWAYS;
		rx_left    = 0;
		rx_phase   = 0;
		last_x     = '0;
		last_y     = '0;
		last_z     = '0;
		foreach (occ_map[v]) begin
			occ_map[v] = 1'b0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The register keeps its reset value while the block clears its map;
		// the first request word is taken only when that pass is over.
		check_overlap_scale();
		test_zero_radius();
		test_periodic_wrap();
		test_undefined_op();
		test_full_grid();
		test_overlap_scale();
		test_random_traffic();

		wait_idle();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
